// ----- design/ansdet_pkg.sv -----
// Shared types, codes and constants of the answering machine detector.
package ansdet_pkg;

    typedef enum logic [1:0] {
        MODE_AUDIO   = 2'd0,
        MODE_HANGUP  = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_START   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        VERDICT_PENDING = 3'd0,
        VERDICT_MACHINE = 3'd1,
        VERDICT_HUMAN   = 3'd2,
        VERDICT_NOTSURE = 3'd3,
        VERDICT_HANGUP  = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_TOOLONG   = 3'd1,
        CAUSE_INITSIL   = 3'd2,
        CAUSE_HUMANSIL  = 3'd3,
        CAUSE_MAXWORDS  = 3'd4,
        CAUSE_LONGGREET = 3'd5
    } cause_t;

    typedef enum logic [2:0] {
        REG_INITIAL_SILENCE  = 3'd0,
        REG_GREETING_MAX     = 3'd1,
        REG_AFTER_GREETING   = 3'd2,
        REG_TOTAL_ANALYSIS   = 3'd3,
        REG_MIN_WORD         = 3'd4,
        REG_BETWEEN_WORDS    = 3'd5,
        REG_MAX_WORDS        = 3'd6
    } reg_idx_t;

    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 16;

    localparam logic [15:0] RST_INITIAL_SILENCE = 16'd2500;
    localparam logic [15:0] RST_GREETING_MAX    = 16'd1500;
    localparam logic [15:0] RST_AFTER_GREETING  = 16'd800;
    localparam logic [15:0] RST_TOTAL_ANALYSIS  = 16'd5000;
    localparam logic [15:0] RST_MIN_WORD        = 16'd100;
    localparam logic [15:0] RST_BETWEEN_WORDS   = 16'd50;
    localparam logic [7:0]  RST_MAX_WORDS       = 8'd3;

    typedef struct packed {
        logic [15:0] initial_silence_ms;
        logic [15:0] greeting_max_ms;
        logic [15:0] after_greeting_silence_ms;
        logic [15:0] total_analysis_ms;
        logic [15:0] min_word_ms;
        logic [15:0] between_words_ms;
        logic [7:0]  max_words;
    } cfg_t;

    typedef struct packed {
        logic [15:0] elapsed_time;
        logic [15:0] voice_time;
        logic [15:0] run_voice_time;
        logic [7:0]  words_seen;
        logic        in_word;
        logic        before_greeting;
        logic        greeting_seen;
        logic        decided;
        verdict_t    held_verdict;
        cause_t      held_cause;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        elapsed_time:    16'd0,
        voice_time:      16'd0,
        run_voice_time:  16'd0,
        words_seen:      8'd0,
        in_word:         1'b0,
        before_greeting: 1'b1,
        greeting_seen:   1'b0,
        decided:         1'b0,
        held_verdict:    VERDICT_PENDING,
        held_cause:      CAUSE_NONE
    };

    typedef struct packed {
        logic        done_res;
        verdict_t    verdict;
        cause_t      cause;
        logic [15:0] total_ms;
        logic [15:0] voice_ms;
        logic [7:0]  word_count;
    } result_t;

    function automatic logic [15:0] sat_add16(logic [15:0] a, logic [7:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ----- design/ansdet_in_if.sv -----
// Frame report channel: valid, ready and the frame fields.
interface ansdet_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  frame_ms;
    logic [15:0] silence_ms;

    modport source (output valid, mode, frame_ms, silence_ms, input ready);
    modport sink   (input valid, mode, frame_ms, silence_ms, output ready);
endinterface

// ----- design/ansdet_out_if.sv -----
// Result channel: valid, ready and the classification fields.
interface ansdet_out_if;
    logic        valid;
    logic        ready;
    logic        done_res;
    logic [2:0]  verdict;
    logic [2:0]  cause;
    logic [15:0] total_ms;
    logic [15:0] voice_ms;
    logic [7:0]  word_count;

    modport source (output valid, done_res, verdict, cause, total_ms, voice_ms, word_count,
                    input ready);
    modport sink   (input valid, done_res, verdict, cause, total_ms, voice_ms, word_count,
                    output ready);
endinterface

// ----- design/answering_machine_detector.sv -----
// Top level of the answering machine detector.
// The result of a frame report appears in the cycle after its transaction.
// Throughput: one transaction per cycle unless a held result is stalled; the state
// update and classification run in one pass from state register to result register.
// Reset: rst_n clears the state, the result valid flag and loads the default limits.
module answering_machine_detector
    import ansdet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_idx,
    input  logic [REG_DATA_W-1:0] wr_data,
    ansdet_in_if.sink             frames,
    ansdet_out_if.source          results
);

    cfg_t    cfg;
    result_t result;
    logic    can_load;
    logic    accept;

    assign frames.ready = can_load;
    assign accept       = frames.valid && can_load;

    ansdet_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .cfg     (cfg)
    );

    ansdet_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .mode       (frames.mode),
        .frame_ms   (frames.frame_ms),
        .silence_ms (frames.silence_ms),
        .result     (result)
    );

    ansdet_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .can_load (can_load),
        .results  (results)
    );

endmodule

// ----- design/ansdet_cfg.sv -----
// Configuration register file with write port.
module ansdet_cfg
    import ansdet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_idx,
    input  logic [REG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx_t'(wr_idx))
                REG_INITIAL_SILENCE: cfg_next.initial_silence_ms        = wr_data;
                REG_GREETING_MAX:    cfg_next.greeting_max_ms           = wr_data;
                REG_AFTER_GREETING:  cfg_next.after_greeting_silence_ms = wr_data;
                REG_TOTAL_ANALYSIS:  cfg_next.total_analysis_ms         = wr_data;
                REG_MIN_WORD:        cfg_next.min_word_ms               = wr_data;
                REG_BETWEEN_WORDS:   cfg_next.between_words_ms          = wr_data;
                REG_MAX_WORDS:       cfg_next.max_words                 = wr_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_silence_ms        <= RST_INITIAL_SILENCE;
            cfg_reg.greeting_max_ms           <= RST_GREETING_MAX;
            cfg_reg.after_greeting_silence_ms <= RST_AFTER_GREETING;
            cfg_reg.total_analysis_ms         <= RST_TOTAL_ANALYSIS;
            cfg_reg.min_word_ms               <= RST_MIN_WORD;
            cfg_reg.between_words_ms          <= RST_BETWEEN_WORDS;
            cfg_reg.max_words                 <= RST_MAX_WORDS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/ansdet_core.sv -----
// Classification state and single-pass update for one frame report.
module ansdet_core
    import ansdet_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        accept,
    input  logic [1:0]  mode,
    input  logic [7:0]  frame_ms,
    input  logic [15:0] silence_ms,
    output result_t     result
);

    state_t st_reg;
    state_t st_next;
    state_t aud;
    logic [15:0] tot_sum;
    logic [15:0] run_sum;
    logic [15:0] voice_sum;
    logic [7:0]  words_inc;
    logic        word_hit;

    assign tot_sum   = sat_add16(st_reg.elapsed_time, frame_ms);
    assign run_sum   = sat_add16(st_reg.run_voice_time, frame_ms);
    assign voice_sum = sat_add16(st_reg.voice_time, frame_ms);
    assign word_hit  = (run_sum >= cfg.min_word_ms) && !st_reg.in_word;
    assign words_inc = (word_hit && (st_reg.words_seen != 8'hFF))
                     ? st_reg.words_seen + 8'd1 : st_reg.words_seen;

    always_comb
    begin
        aud = st_reg;
        aud.elapsed_time = tot_sum;
        if (tot_sum >= cfg.total_analysis_ms)
        begin
            aud.decided      = 1'b1;
            aud.held_verdict = VERDICT_NOTSURE;
            aud.held_cause   = CAUSE_TOOLONG;
        end
        else if (silence_ms != 16'd0)
        begin
            if (silence_ms >= cfg.between_words_ms)
            begin
                aud.in_word        = 1'b0;
                aud.run_voice_time = 16'd0;
            end
            if (st_reg.before_greeting && (silence_ms >= cfg.initial_silence_ms))
            begin
                aud.decided      = 1'b1;
                aud.held_verdict = VERDICT_MACHINE;
                aud.held_cause   = CAUSE_INITSIL;
            end
            else if (st_reg.greeting_seen && (silence_ms >= cfg.after_greeting_silence_ms))
            begin
                aud.decided      = 1'b1;
                aud.held_verdict = VERDICT_HUMAN;
                aud.held_cause   = CAUSE_HUMANSIL;
            end
        end
        else
        begin
            aud.run_voice_time = run_sum;
            aud.voice_time     = voice_sum;
            aud.words_seen     = words_inc;
            aud.in_word        = st_reg.in_word | word_hit;
            if (words_inc >= cfg.max_words)
            begin
                aud.decided      = 1'b1;
                aud.held_verdict = VERDICT_MACHINE;
                aud.held_cause   = CAUSE_MAXWORDS;
            end
            else if (st_reg.greeting_seen && (voice_sum >= cfg.greeting_max_ms))
            begin
                aud.decided      = 1'b1;
                aud.held_verdict = VERDICT_MACHINE;
                aud.held_cause   = CAUSE_LONGGREET;
            end
            else if (voice_sum >= cfg.min_word_ms)
            begin
                aud.before_greeting = 1'b0;
                aud.greeting_seen   = 1'b1;
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (mode_t'(mode))
            MODE_START:
                st_next = STATE_CLEAR;
            MODE_AUDIO:
                if (!st_reg.decided)
                    st_next = aud;
            MODE_HANGUP:
                if (!st_reg.decided)
                begin
                    st_next.decided      = 1'b1;
                    st_next.held_verdict = VERDICT_HANGUP;
                    st_next.held_cause   = CAUSE_NONE;
                end
            MODE_TIMEOUT:
                if (!st_reg.decided)
                begin
                    st_next.decided      = 1'b1;
                    st_next.held_verdict = VERDICT_NOTSURE;
                    st_next.held_cause   = CAUSE_TOOLONG;
                end
            default:
                st_next = st_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= STATE_CLEAR;
        else if (accept)
            st_reg <= st_next;
    end

    assign result.done_res   = st_next.decided;
    assign result.verdict    = st_next.held_verdict;
    assign result.cause      = st_next.held_cause;
    assign result.total_ms   = st_next.elapsed_time;
    assign result.voice_ms   = st_next.voice_time;
    assign result.word_count = st_next.words_seen;

endmodule

// ----- design/ansdet_out_reg.sv -----
// Result register between the update logic and the result channel.
module ansdet_out_reg
    import ansdet_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    can_load,
    ansdet_out_if.source results
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || results.ready;
    assign valid_next = load || (valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign results.valid      = valid_reg;
    assign results.done_res   = data_reg.done_res;
    assign results.verdict    = data_reg.verdict;
    assign results.cause      = data_reg.cause;
    assign results.total_ms   = data_reg.total_ms;
    assign results.voice_ms   = data_reg.voice_ms;
    assign results.word_count = data_reg.word_count;

endmodule

// ----- design/ansdet_checker.sv -----
// Port-level checks of the answering machine detector and their binding.
module ansdet_checker
    import ansdet_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_mode,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_done,
    input logic [2:0]  out_verdict,
    input logic [2:0]  out_cause,
    input logic [15:0] out_total,
    input logic [15:0] out_voice,
    input logic [7:0]  out_words
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_total) && $stable(out_verdict))
        else $error("stalled result changed");

    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("transaction produced no result");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == MODE_START) |=>
        !out_done && (out_total == 16'd0) && (out_voice == 16'd0) && (out_words == 8'd0))
        else $error("start did not clear the result");

    a_pending_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_done == (out_verdict != VERDICT_PENDING))
                   && (out_done || (out_cause == CAUSE_NONE)))
        else $error("verdict inconsistent with done flag");

    a_voice_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_voice <= out_total)
        else $error("voice time exceeds total time");

endmodule

bind answering_machine_detector ansdet_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (frames.valid),
    .in_ready    (frames.ready),
    .in_mode     (frames.mode),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_done    (results.done_res),
    .out_verdict (results.verdict),
    .out_cause   (results.cause),
    .out_total   (results.total_ms),
    .out_voice   (results.voice_ms),
    .out_words   (results.word_count)
);
